// ===== rtl/core/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Types and codes shared by the fixed-point ALU front end, queue and back end.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // Operation codes as they arrive on the input stream.
  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_LT       = 4'd4,
    CMD_GT       = 4'd5,
    CMD_LE       = 4'd6,
    CMD_GE       = 4'd7,
    CMD_EQ       = 4'd8,
    CMD_NE       = 4'd9,
    CMD_MIN      = 4'd10,
    CMD_MAX      = 4'd11,
    CMD_INC      = 4'd12,
    CMD_DEC      = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_TO_INT   = 4'd15
  } cmd_t;

  // Status codes of a result word.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_OVF  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  localparam logic [31:0] RAW_MAX = 32'h7fff_ffff;
  localparam logic [31:0] RAW_MIN = 32'h8000_0000;

  // How the back end must finish an item.
  typedef enum logic [1:0] {
    KIND_DONE = 2'd0,
    KIND_MUL  = 2'd1,
    KIND_DIV  = 2'd2
  } kind_t;

  // One classified item between front end and back end.
  typedef struct packed {
    kind_t       kind;
    logic        neg;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [31:0] res;
    logic        cmp;
    logic [1:0]  st;
  } item_t;

endpackage

// ===== rtl/core/fpa_front.sv =====
// ----------------------------------------------------------------------------
// fpa_front
// Accepts input words, finishes the simple operations and classifies
// multiply and divide for the back end.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int FRAC_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [3:0]     in_cmd,
  input  logic [31:0]    in_a,
  input  logic [31:0]    in_b,
  output logic           out_valid,
  input  logic           out_ready,
  output fpa_pkg::item_t out_item
);

  logic           front_valid;
  fpa_pkg::item_t front_item;
  fpa_pkg::item_t item_next;

  logic [63:0] shifted;
  logic        from_ovf;
  logic        lt;

  // Clamp a 33-bit sum to 32 signed bits.
  function automatic logic [33:0] sat33(input logic [32:0] s);
    logic [33:0] r;
    r = {fpa_pkg::ST_OK, s[31:0]};
    if (s[32] != s[31]) begin
      r = {fpa_pkg::ST_OVF, (s[32] ? fpa_pkg::RAW_MIN : fpa_pkg::RAW_MAX)};
    end
    return r;
  endfunction

  assign shifted  = {{32{in_a[31]}}, in_a} << FRAC_BITS;
  assign from_ovf = !(&shifted[63:31]) && (|shifted[63:31]);
  assign lt       = $signed(in_a) < $signed(in_b);

  // Classify and evaluate the simple operations.
  always_comb begin
    item_next       = '0;
    item_next.kind  = fpa_pkg::KIND_DONE;
    item_next.neg   = in_a[31] ^ in_b[31];
    item_next.mag_a = in_a[31] ? (~in_a + 32'd1) : in_a;
    item_next.mag_b = in_b[31] ? (~in_b + 32'd1) : in_b;
    item_next.st    = fpa_pkg::ST_OK;
    case (fpa_pkg::cmd_t'(in_cmd))
      fpa_pkg::CMD_ADD: begin
        {item_next.st, item_next.res} = sat33({in_a[31], in_a} + {in_b[31], in_b});
      end
      fpa_pkg::CMD_SUB: begin
        {item_next.st, item_next.res} = sat33({in_a[31], in_a} - {in_b[31], in_b});
      end
      fpa_pkg::CMD_MUL: item_next.kind = fpa_pkg::KIND_MUL;
      fpa_pkg::CMD_DIV: begin
        if (in_b == 32'd0) begin
          item_next.st = fpa_pkg::ST_DIV0;
        end else begin
          item_next.kind = fpa_pkg::KIND_DIV;
        end
      end
      fpa_pkg::CMD_LT: item_next.cmp = lt;
      fpa_pkg::CMD_GT: item_next.cmp = !lt && (in_a != in_b);
      fpa_pkg::CMD_LE: item_next.cmp = lt || (in_a == in_b);
      fpa_pkg::CMD_GE: item_next.cmp = !lt;
      fpa_pkg::CMD_EQ: item_next.cmp = in_a == in_b;
      fpa_pkg::CMD_NE: item_next.cmp = in_a != in_b;
      fpa_pkg::CMD_MIN: item_next.res = lt ? in_a : in_b;
      fpa_pkg::CMD_MAX: item_next.res = lt ? in_b : in_a;
      fpa_pkg::CMD_INC: begin
        {item_next.st, item_next.res} = sat33({in_a[31], in_a} + 33'd1);
      end
      fpa_pkg::CMD_DEC: begin
        {item_next.st, item_next.res} = sat33({in_a[31], in_a} - 33'd1);
      end
      fpa_pkg::CMD_FROM_INT: begin
        if (from_ovf) begin
          item_next.st  = fpa_pkg::ST_OVF;
          item_next.res = in_a[31] ? fpa_pkg::RAW_MIN : fpa_pkg::RAW_MAX;
        end else begin
          item_next.res = shifted[31:0];
        end
      end
      fpa_pkg::CMD_TO_INT: item_next.res = 32'($signed(in_a) >>> FRAC_BITS);
      default: item_next.res = '0;
    endcase
  end

  assign in_ready  = !front_valid || out_ready;
  assign out_valid = front_valid;
  assign out_item  = front_item;

  // Front register, refilled whenever its word moves on.
  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (in_ready) begin
      front_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      front_item <= item_next;
    end
  end

endmodule

// ===== rtl/core/fpa_queue.sv =====
// ----------------------------------------------------------------------------
// fpa_queue
// Two-entry queue that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module fpa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fpa_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output fpa_pkg::item_t pop_item
);

  fpa_pkg::item_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = count == 2'd2;
  assign not_empty = count != 2'd0;
  assign pop_item  = slots[rd_ptr];

  // Pointer and fill count update.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

endmodule

// ===== rtl/core/fpa_div.sv =====
// ----------------------------------------------------------------------------
// fpa_div
// Pipelined restoring divider, one quotient bit per stage, carrying the item
// alongside so every word keeps its place in the stream.
// ----------------------------------------------------------------------------
module fpa_div #(
  parameter int NUMW = 40
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  fpa_pkg::item_t  in_item,
  input  logic [NUMW-1:0] in_num,
  input  logic [31:0]     in_den,
  output logic            out_valid,
  output fpa_pkg::item_t  out_item,
  output logic [NUMW-1:0] out_quot,
  output logic [31:0]     out_rem,
  output logic [31:0]     out_den
);

  logic            v   [NUMW];
  fpa_pkg::item_t  itm [NUMW];
  logic [31:0]     rem [NUMW];
  logic [NUMW-1:0] nq  [NUMW];
  logic [31:0]     dn  [NUMW];

  genvar i;
  generate
    for (i = 0; i < NUMW; i++) begin : g_stage
      logic            pv;
      fpa_pkg::item_t  pitm;
      logic [31:0]     prem;
      logic [NUMW-1:0] pnq;
      logic [31:0]     pdn;
      logic [32:0]     t;
      logic            ge;
      logic [32:0]     diff;

      // Inputs of this stage come from the previous one.
      if (i == 0) begin : g_first
        assign pv   = in_valid;
        assign pitm = in_item;
        assign prem = '0;
        assign pnq  = in_num;
        assign pdn  = in_den;
      end else begin : g_rest
        assign pv   = v[i-1];
        assign pitm = itm[i-1];
        assign prem = rem[i-1];
        assign pnq  = nq[i-1];
        assign pdn  = dn[i-1];
      end

      // Shift in one numerator bit and try to subtract the divisor.
      assign t    = {prem, pnq[NUMW-1]};
      assign ge   = t >= {1'b0, pdn};
      assign diff = t - {1'b0, pdn};

      always_ff @(posedge clk) begin
        if (rst) begin
          v[i] <= 1'b0;
        end else if (en) begin
          v[i] <= pv;
        end
        if (en) begin
          itm[i] <= pitm;
          rem[i] <= ge ? diff[31:0] : t[31:0];
          nq[i]  <= {pnq[NUMW-2:0], ge};
          dn[i]  <= pdn;
        end
      end
    end
  endgenerate

  assign out_valid = v[NUMW-1];
  assign out_item  = itm[NUMW-1];
  assign out_quot  = nq[NUMW-1];
  assign out_rem   = rem[NUMW-1];
  assign out_den   = dn[NUMW-1];

endmodule

// ===== rtl/core/fpa_back.sv =====
// ----------------------------------------------------------------------------
// fpa_back
// Multiply stages, divider pipeline and the final rounding stage that holds
// the output word.
// ----------------------------------------------------------------------------
module fpa_back #(
  parameter int FRAC_BITS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_pop,
  input  fpa_pkg::item_t in_item,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [31:0]    out_res,
  output logic           out_cmp,
  output logic [1:0]     out_st
);

  localparam int NUMW = 32 + FRAC_BITS;

  logic adv;

  logic            a_valid;
  fpa_pkg::item_t  a_item;
  logic [63:0]     a_prod;
  logic [NUMW-1:0] a_num;
  logic [31:0]     a_den;

  logic            b_valid;
  fpa_pkg::item_t  b_item;
  logic [NUMW-1:0] b_num;
  logic [31:0]     b_den;
  fpa_pkg::item_t  b_item_next;
  logic [63:0]     mul_q;

  logic            d_valid;
  fpa_pkg::item_t  d_item;
  logic [NUMW-1:0] d_quot;
  logic [31:0]     d_rem;
  logic [31:0]     d_den;
  logic            d_up;
  logic [63:0]     div_q;

  // Saturate a rounded magnitude with its sign to a 32-bit raw value.
  function automatic logic [33:0] sat_mag(input logic [63:0] q, input logic neg);
    logic [33:0] r;
    if (neg) begin
      if (q > 64'h0000_0000_8000_0000) begin
        r = {fpa_pkg::ST_OVF, fpa_pkg::RAW_MIN};
      end else begin
        r = {fpa_pkg::ST_OK, ~q[31:0] + 32'd1};
      end
    end else begin
      if (q > 64'h0000_0000_7fff_ffff) begin
        r = {fpa_pkg::ST_OVF, fpa_pkg::RAW_MAX};
      end else begin
        r = {fpa_pkg::ST_OK, q[31:0]};
      end
    end
    return r;
  endfunction

  // The whole back end moves as one when the output word is free.
  assign adv    = !out_valid || out_ready;
  assign in_pop = adv && in_valid;

  // Stage A: magnitude product and divider operands.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
    if (adv) begin
      a_item <= in_item;
      a_prod <= in_item.mag_a * in_item.mag_b;
      a_num  <= {in_item.mag_a, FRAC_BITS'(0)};
      a_den  <= in_item.mag_b;
    end
  end

  // Stage B: round the product half away from zero and saturate.
  assign mul_q = (a_prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;

  always_comb begin
    b_item_next = a_item;
    if (a_item.kind == fpa_pkg::KIND_MUL) begin
      {b_item_next.st, b_item_next.res} = sat_mag(mul_q, a_item.neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
    if (adv) begin
      b_item <= b_item_next;
      b_num  <= a_num;
      b_den  <= a_den;
    end
  end

  fpa_div #(
    .NUMW(NUMW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (b_valid),
    .in_item  (b_item),
    .in_num   (b_num),
    .in_den   (b_den),
    .out_valid(d_valid),
    .out_item (d_item),
    .out_quot (d_quot),
    .out_rem  (d_rem),
    .out_den  (d_den)
  );

  // Final stage: round the quotient up when twice the remainder reaches the divisor.
  assign d_up  = {d_rem, 1'b0} >= {1'b0, d_den};
  assign div_q = 64'(d_quot) + 64'(d_up);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid;
    end
    if (adv) begin
      out_cmp <= d_item.cmp;
      if (d_item.kind == fpa_pkg::KIND_DIV) begin
        {out_st, out_res} <= sat_mag(div_q, d_item.neg);
      end else begin
        out_st  <= d_item.st;
        out_res <= d_item.res;
      end
    end
  end

endmodule

// ===== rtl/core/fixed_point_alu_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Signed fixed-point ALU on 32-bit raw values with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one operation per word: the opcode in s_tuser
//   and the two raw operands in s_tdata. The output stream returns exactly
//   one word per operation, in order, with the raw result, the comparison
//   outcome and the status code.
//   A front register evaluates the simple operations and classifies
//   multiply and divide; a two-entry queue feeds the back end, which runs
//   every word through the multiply stages and a divider pipeline of one
//   quotient bit per stage, so all words keep their order.
//   An accepted input word passes the front register, a queue slot, the two
//   multiply stages, the 32 + FRAC_BITS divider stages and the output word.
//   Throughput is one word per cycle, any opcode, while m_tready is high.
//   When the receiver holds m_tready low the back end freezes as a whole,
//   the queue fills, and then s_tready drops; no word is lost.
//   Reset clears all valid bits; the block is ready right after reset.
// ----------------------------------------------------------------------------
module fixed_point_alu_unit #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_a [31:0], operand_b [63:32]
  input  logic [3:0]  s_tuser,   // cmd [3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // result_value [31:0], compare_true [32],
                                 // status [34:33], zero fill [39:35]
);

  logic           f_valid;
  fpa_pkg::item_t f_item;
  logic           q_full;
  logic           q_push;
  logic           q_not_empty;
  logic           q_pop;
  fpa_pkg::item_t q_item;
  logic [31:0]    res;
  logic           cmp;
  logic [1:0]     st;

  fpa_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_cmd   (s_tuser),
    .in_a     (s_tdata[31:0]),
    .in_b     (s_tdata[63:32]),
    .out_valid(f_valid),
    .out_ready(!q_full),
    .out_item (f_item)
  );

  assign q_push = f_valid && !q_full;

  fpa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(f_item),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_item (q_item)
  );

  fpa_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_not_empty),
    .in_pop   (q_pop),
    .in_item  (q_item),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (res),
    .out_cmp  (cmp),
    .out_st   (st)
  );

  assign m_tdata = {5'd0, st, cmp, res};

  // A division by zero gives a zero result and no comparison flag.
  a_div0_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && st == fpa_pkg::ST_DIV0) |-> (res == 32'd0 && !cmp))
    else $error("division by zero word carries a nonzero result");

  // A true comparison carries a zero value and a clean status.
  a_cmp_clean : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && cmp) |-> (res == 32'd0 && st == fpa_pkg::ST_OK))
    else $error("comparison word carries a value or a status");

  // A saturated result sits on one of the two bounds.
  a_ovf_bound : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && st == fpa_pkg::ST_OVF) |->
      (res == fpa_pkg::RAW_MAX || res == fpa_pkg::RAW_MIN))
    else $error("overflow word not saturated");

  // The input side stalls only while the front register holds a word.
  a_stall_held : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> f_valid)
    else $error("input stalled with an empty front register");

endmodule

// ===== tb/tb_fixed_point_alu_unit.sv =====
// ----------------------------------------------------------------------------
// tb_fixed_point_alu_unit
// Self-checking bench for the fixed-point ALU: directed corner operations,
// a long receiver hold-off, then random operations with random gaps on both
// streams. Every output word is checked against a local predictor.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 8;
  localparam int LATENCY = FRAC + 45;

  typedef struct packed {
    logic [1:0]  st;
    logic        cmp;
    logic [31:0] value;
  } alu_word_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic [3:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;

  alu_word_t expected_words[$];
  int        error_count;
  bit        hold_off;
  bit        sink_random;

  fixed_point_alu_unit #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #100ms;
    $display("Some tests failed");
    $finish;
  end

  // Clamp a wide signed value to 32 bits and flag overflow.
  function automatic logic [31:0] saturate(input logic signed [95:0] x,
                                           inout logic [1:0] st);
    if (x > 96'sh7fff_ffff) begin
      st = fpa_pkg::ST_OVF;
      return fpa_pkg::RAW_MAX;
    end
    if (x < -96'sh8000_0000) begin
      st = fpa_pkg::ST_OVF;
      return fpa_pkg::RAW_MIN;
    end
    return x[31:0];
  endfunction

  // Quotient rounded half away from zero, sign applied afterwards.
  function automatic logic signed [95:0] rounded_quotient(input logic [95:0] num,
                                                          input logic [95:0] den,
                                                          input bit neg);
    logic [95:0] q;
    q = (2 * num + den) / (2 * den);
    return neg ? -$signed(q) : $signed(q);
  endfunction

  function automatic alu_word_t alu_predict(input fpa_pkg::cmd_t cmd,
                                            input logic [31:0] a_raw,
                                            input logic [31:0] b_raw);
    logic signed [95:0] a, b, prod;
    logic [95:0] mag_a, mag_b;
    alu_word_t w;
    a = $signed(a_raw);
    b = $signed(b_raw);
    mag_a = a < 0 ? -a : a;
    mag_b = b < 0 ? -b : b;
    w = '0;
    w.st = fpa_pkg::ST_OK;
    case (cmd)
      fpa_pkg::CMD_ADD: w.value = saturate(a + b, w.st);
      fpa_pkg::CMD_SUB: w.value = saturate(a - b, w.st);
      fpa_pkg::CMD_MUL: begin
        prod = mag_a * mag_b;
        w.value = saturate(rounded_quotient(prod, 96'd1 << FRAC, (a < 0) != (b < 0)),
                           w.st);
      end
      fpa_pkg::CMD_DIV: begin
        if (b == 0) w.st = fpa_pkg::ST_DIV0;
        else w.value = saturate(rounded_quotient(mag_a << FRAC, mag_b,
                                                 (a < 0) != (b < 0)), w.st);
      end
      fpa_pkg::CMD_LT: w.cmp = a < b;
      fpa_pkg::CMD_GT: w.cmp = a > b;
      fpa_pkg::CMD_LE: w.cmp = a <= b;
      fpa_pkg::CMD_GE: w.cmp = a >= b;
      fpa_pkg::CMD_EQ: w.cmp = a == b;
      fpa_pkg::CMD_NE: w.cmp = a != b;
      fpa_pkg::CMD_MIN: w.value = a < b ? a_raw : b_raw;
      fpa_pkg::CMD_MAX: w.value = a < b ? b_raw : a_raw;
      fpa_pkg::CMD_INC: w.value = saturate(a + 1, w.st);
      fpa_pkg::CMD_DEC: w.value = saturate(a - 1, w.st);
      fpa_pkg::CMD_FROM_INT: w.value = saturate(a * (96'sd1 <<< FRAC), w.st);
      default: w.value = $signed(a_raw) >>> FRAC;
    endcase
    return w;
  endfunction

  // Offer one word after a random gap; the prediction is queued on acceptance.
  // Valid stays high into the next call so that words can follow back to back.
  task automatic send_op(input fpa_pkg::cmd_t cmd, input logic [31:0] a,
                         input logic [31:0] b);
    int gap;
    gap = $urandom_range(3) == 0 ? 0 : $urandom_range(13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {b, a};
    do @(posedge clk); while (!s_tready);
    expected_words.push_back(alu_predict(cmd, a, b));
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(7))
      0: return $urandom_range(1) ? fpa_pkg::RAW_MAX : fpa_pkg::RAW_MIN;
      1: return $urandom_range(2) - 1;
      2: return $signed($urandom_range(4095)) - 2048;
      3: return $signed($urandom_range(1 << 20)) - (1 << 19);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_corners();
    logic [31:0] vals[6];
    vals = '{fpa_pkg::RAW_MAX, fpa_pkg::RAW_MIN, 32'd0, 32'hffff_ffff, 32'd256,
             32'hffff_ff80};
    send_op(fpa_pkg::CMD_ADD, fpa_pkg::RAW_MAX, 32'd1);
    send_op(fpa_pkg::CMD_SUB, fpa_pkg::RAW_MIN, 32'd1);
    send_op(fpa_pkg::CMD_MUL, fpa_pkg::RAW_MAX, fpa_pkg::RAW_MAX);
    send_op(fpa_pkg::CMD_MUL, 32'd384, 32'hffff_ff80);
    send_op(fpa_pkg::CMD_DIV, 32'd1000, 32'd0);
    send_op(fpa_pkg::CMD_DIV, fpa_pkg::RAW_MIN, 32'hffff_ffff);
    send_op(fpa_pkg::CMD_DIV, 32'd1, 32'd3);
    send_op(fpa_pkg::CMD_INC, fpa_pkg::RAW_MAX, 32'd0);
    send_op(fpa_pkg::CMD_DEC, fpa_pkg::RAW_MIN, 32'd0);
    send_op(fpa_pkg::CMD_FROM_INT, 32'h0080_0000, 32'd0);
    send_op(fpa_pkg::CMD_FROM_INT, fpa_pkg::RAW_MIN, 32'd0);
    send_op(fpa_pkg::CMD_TO_INT, 32'hffff_fe7f, 32'd0);
    send_op(fpa_pkg::CMD_MIN, 32'd5, 32'd5);
    send_op(fpa_pkg::CMD_MAX, fpa_pkg::RAW_MIN, fpa_pkg::RAW_MAX);
    for (int c = fpa_pkg::CMD_LT; c <= fpa_pkg::CMD_NE; c++)
      send_op(fpa_pkg::cmd_t'(c), vals[$urandom_range(5)], vals[$urandom_range(5)]);
  endtask

  // The receiver holds off for a long stretch while words keep coming.
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < 80; i++)
      send_op(fpa_pkg::cmd_t'($urandom_range(15)), rand_operand(), rand_operand());
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++)
      send_op(fpa_pkg::cmd_t'($urandom_range(15)), rand_operand(), rand_operand());
  endtask

  // Receiver readiness: random stalls, or always ready, or held off.
  initial begin
    int stall;
    m_tready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = sink_random ? $urandom_range(13) : 0;
      if (stall > 0 || hold_off) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // Compare every accepted output word with the oldest prediction.
  always @(posedge clk) begin
    alu_word_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[34:0];
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", m_tdata);
        error_count++;
      end else begin
        want = expected_words.pop_front();
        if (got.value !== want.value) begin
          $error("result_value expected %h actual %h", want.value, got.value);
          error_count++;
        end
        if (got.cmp !== want.cmp) begin
          $error("compare_true expected %b actual %b", want.cmp, got.cmp);
          error_count++;
        end
        if (got.st !== want.st) begin
          $error("status expected %0d actual %0d", want.st, got.st);
          error_count++;
        end
      end
    end
  end

  initial begin
    error_count = 0;
    hold_off = 1'b0;
    sink_random = 1'b0;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= fpa_pkg::CMD_ADD;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corners();
    sink_random = 1'b1;
    test_backpressure();
    test_random(500);
    sink_random = 1'b0;
    test_random(250);
    sink_random = 1'b1;
    test_random(300);
    s_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
